@@ design/bsts_pkg.sv @@
// Package for the best split threshold search core.
// Holds field widths and the score and count types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bsts_pkg;
    localparam int SCORE_W = 32;
    localparam int CNT_W   = 11;
    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [CNT_W-1:0] cnt_t;
endpackage
`default_nettype wire

@@ design/bsts_store.sv @@
// Item store for the threshold search: one memory holding score and label.
// Depends on bsts_pkg for the score type.
`timescale 1ns / 1ps
`default_nettype none
module bsts_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                   aclk,
    input  wire                   wr_en,
    input  wire  [AW-1:0]         wr_addr,
    input  wire  bsts_pkg::score_t wr_score,
    input  wire                   wr_label,
    input  wire  [AW-1:0]         rd_addr,
    output bsts_pkg::score_t      rd_score,
    output logic                  rd_label
);
    import bsts_pkg::*;
    logic [SCORE_W:0] mem [DEPTH];
    logic [SCORE_W:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_label, wr_score};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_score = rd_reg[SCORE_W-1:0];
    assign rd_label = rd_reg[SCORE_W];
endmodule
`default_nettype wire

@@ design/best_split_threshold_search_core.sv @@
// Top level of the best split threshold search core.
// Uses bsts_pkg and bsts_store; one sequencer drives a single compare unit.
`timescale 1ns / 1ps
`default_nettype none
// Each item is placed in sorted order by an insertion sweep through the store:
// the sequencer reads one entry, compares it with the new score and shifts it
// up, repeating for each stored entry above its score, through the single store
// port pair. The final item then starts a sweep over the n sorted entries to
// find the split with fewest errors before the result is offered. Items beyond
// MAX_ITEMS are dropped and flagged.
module best_split_threshold_search_core #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,  // is_class_one, score
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,  // best_threshold, fewest_errors, item_total, overflowed
    output logic        m_tlast
);
    import bsts_pkg::*;
    localparam int AW = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = AW + 1;
    localparam logic [NW-1:0] MAXN = NW'(MAX_ITEMS);

    localparam logic [2:0] ST_IDLE = 3'd0, ST_IRD = 3'd1, ST_ICMP = 3'd2,
                           ST_SRD = 3'd3, ST_SWAIT = 3'd4, ST_SCAN = 3'd5,
                           ST_OUT = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] count_reg, ones_reg, pos_reg, idx_reg;
    logic [NW-1:0] ole_reg, ile_reg, best_err_reg;
    score_t        new_score_reg, best_thr_reg;
    logic          new_label_reg, last_reg, ovf_reg, have_reg;

    logic          wr_en, rd_label;
    logic [AW-1:0] wr_addr, rd_addr;
    score_t        wr_score, rd_score;
    logic          wr_label;

    bsts_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_score(wr_score),
        .wr_label(wr_label), .rd_addr(rd_addr), .rd_score(rd_score), .rd_label(rd_label)
    );

    logic [NW-1:0] ole_n, ile_n, err_n;
    logic          gt;
    assign gt    = rd_score > new_score_reg;
    assign ole_n = ole_reg + NW'(!rd_label);
    assign ile_n = ile_reg + NW'(rd_label);
    assign err_n = ole_n + (ones_reg - ile_n);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = 1'b1;
    assign m_tdata  = {1'b0, ovf_reg, cnt_t'(count_reg), cnt_t'(best_err_reg), best_thr_reg};

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = pos_reg[AW-1:0];
        wr_score = new_score_reg;
        wr_label = new_label_reg;
        rd_addr  = idx_reg[AW-1:0];
        if (state_reg == ST_ICMP) begin
            wr_en = 1'b1;
            if (pos_reg != '0 && gt) begin
                wr_score = rd_score;
                wr_label = rd_label;
            end
        end
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = (count_reg < MAXN) ? ST_IRD
                                              : (s_tlast ? ST_SRD : ST_IDLE);
            ST_IRD:   state_next = ST_ICMP;
            ST_ICMP:  if (pos_reg != '0 && gt) state_next = ST_IRD;
                      else state_next = last_reg ? ST_SRD : ST_IDLE;
            ST_SRD:   state_next = ST_SWAIT;
            ST_SWAIT: state_next = (count_reg <= NW'(1)) ? ST_OUT : ST_SCAN;
            ST_SCAN:  if (idx_reg == count_reg) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ones_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    new_score_reg <= s_tdata[32:1];
                    new_label_reg <= s_tdata[0];
                    last_reg      <= s_tlast;
                    pos_reg       <= count_reg;
                    idx_reg       <= count_reg - NW'(1);
                    if (count_reg < MAXN) begin
                        count_reg <= count_reg + NW'(1);
                        ones_reg  <= ones_reg + NW'(s_tdata[0]);
                    end else begin
                        ovf_reg <= 1'b1;
                        idx_reg <= '0;
                    end
                end
                ST_ICMP: begin
                    if (pos_reg != '0 && gt) begin
                        pos_reg <= pos_reg - NW'(1);
                        idx_reg <= pos_reg - NW'(2);
                    end else begin
                        idx_reg <= '0;
                    end
                end
                ST_SRD: begin
                    idx_reg      <= NW'(1);
                    ole_reg      <= '0;
                    ile_reg      <= '0;
                    have_reg     <= 1'b0;
                    best_err_reg <= '0;
                    best_thr_reg <= '0;
                end
                ST_SWAIT, ST_SCAN: if (count_reg != '0) begin
                    ole_reg <= ole_n;
                    ile_reg <= ile_n;
                    idx_reg <= idx_reg + NW'(1);
                    if (!have_reg || err_n < best_err_reg) begin
                        have_reg     <= 1'b1;
                        best_err_reg <= err_n;
                        best_thr_reg <= rd_score;
                    end
                end
                ST_OUT: if (m_tready) begin
                    count_reg <= '0;
                    ones_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/bsts_checker.sv @@
// Port-level checker for the best split threshold search core.
// Bound to best_split_threshold_search_core; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module bsts_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata
);
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready)) else $error("input open while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[42:32] <= m_tdata[53:43]) else $error("errors exceed total");
endmodule
bind best_split_threshold_search_core bsts_checker u_bsts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
